// ----- rtl/chpm_pkg.sv -----
// Shared types and constants for the chained hash producer map.
package chpm_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_WMARK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
  localparam int          MIX_SHIFT = 33;
  localparam logic [31:0] NO_TASK   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] handle;
    logic [30:0] task_id;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] producer_task;
  } rsp_t;

  // control between the top-level sequencer and the hash unit
  typedef struct packed {
    logic start;
    logic done;
  } hash_ctl_t;

endpackage

// ----- rtl/chained_hash_producer_map.sv -----
// Top level: chained hash map from tensor handles to producer task ids.
//   channel | dir | handshake         | payload
//   req     | in  | req_valid/ready   | chpm_pkg::req_t
//   rsp     | out | rsp_valid/ready   | chpm_pkg::rsp_t
// Insert, and a lookup of an empty bucket, go through accept, hashing, the
// bucket head read/update and the result; a lookup also visits each chain entry
// in turn (one pool RAM read each, in ST_READ then ST_CHECK).
// Set watermark and clear go from accept straight to the result. Clear sweeps all bucket valid bits at once.
// Reset empties all buckets, zeroes the ring slot and watermark.
// One transaction at a time; req_ready is low until the result is taken.
module chained_hash_producer_map #(
  parameter int BUCKET_COUNT = 256,
  parameter int SLOT_COUNT   = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  chpm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output chpm_pkg::rsp_t  rsp
);
  import chpm_pkg::*;

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int EW = 64 + 31 + 1 + SW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HASH  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]  state;
  req_t        cur;
  logic [SW-1:0] ring_slot;
  logic [30:0] live_watermark;
  logic [BUCKET_COUNT-1:0] head_ok;
  logic [BW-1:0] bucket;
  logic [BW-1:0] hbucket;
  logic [SW-1:0] walk_slot;
  logic [CW-1:0] steps;

  hash_ctl_t   hctl;
  logic [63:0] hash;

  logic          head_we;
  logic [BW-1:0] head_addr;
  logic [SW-1:0] head_rdata;

  logic          pool_we;
  logic [SW-1:0] pool_addr;
  logic [EW-1:0] pool_wdata;
  logic [EW-1:0] pool_rdata;
  logic [63:0]   e_key;
  logic [30:0]   e_task;
  logic          e_lok;
  logic [SW-1:0] e_lslot;

  assign {e_key, e_task, e_lok, e_lslot} = pool_rdata;

  // key is sampled only on start, which happens at the accepting edge
  chpm_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hctl.start),
    .key   (req.handle),
    .done  (hctl.done),
    .hash  (hash)
  );

  chpm_ram #(.WIDTH(SW), .DEPTH(1 << BW)) u_heads (
    .clk   (clk),
    .we    (head_we),
    .addr  (head_addr),
    .wdata (ring_slot),
    .rdata (head_rdata)
  );

  chpm_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .addr  (pool_addr),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );

  assign hbucket = (BUCKET_COUNT > 1) ? hash[BW-1:0] & BW'(BUCKET_COUNT - 1) : '0;

  // head slot is read on the last hashing cycle so it is ready in ST_HEAD
  assign head_addr  = (state == ST_HASH) ? hbucket : bucket;
  assign head_we    = (state == ST_HEAD) && (cur.mode == MODE_INSERT);

  assign req_ready  = (state == ST_IDLE);
  assign hctl.start = (state == ST_IDLE) && req_valid &&
                      (req.mode == MODE_INSERT || req.mode == MODE_LOOKUP);
  assign pool_we    = (state == ST_HEAD) && (cur.mode == MODE_INSERT);
  assign pool_addr  = (state == ST_HEAD && cur.mode == MODE_INSERT) ? ring_slot : walk_slot;
  assign pool_wdata = {cur.handle, cur.task_id, head_ok[bucket], head_rdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rsp_valid      <= 1'b0;
      ring_slot      <= '0;
      live_watermark <= '0;
      head_ok        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur                   <= req;
            rsp.found             <= 1'b0;
            rsp.producer_task     <= NO_TASK;
            if (req.mode == MODE_WMARK) begin
              live_watermark <= req.task_id;
              state          <= ST_RESP;
              rsp_valid      <= 1'b1;
            end else if (req.mode == MODE_CLEAR) begin
              head_ok   <= '0;
              ring_slot <= '0;
              state     <= ST_RESP;
              rsp_valid <= 1'b1;
            end else begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (hctl.done) begin
            bucket <= hbucket;
            state  <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (cur.mode == MODE_INSERT) begin
            head_ok[bucket] <= 1'b1;
            ring_slot <= (ring_slot == SW'(SLOT_COUNT - 1)) ? '0 : ring_slot + 1'b1;
            state     <= ST_RESP;
            rsp_valid <= 1'b1;
          end else if (!head_ok[bucket]) begin
            state     <= ST_RESP;
            rsp_valid <= 1'b1;
          end else begin
            walk_slot <= head_rdata;
            steps     <= '0;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (e_key == cur.handle && e_task >= live_watermark) begin
            rsp.found         <= 1'b1;
            rsp.producer_task <= {1'b0, e_task};
            state             <= ST_RESP;
            rsp_valid         <= 1'b1;
          end else if (!e_lok || steps == CW'(SLOT_COUNT - 1)) begin
            state     <= ST_RESP;
            rsp_valid <= 1'b1;
          end else begin
            walk_slot <= e_lslot;
            steps     <= steps + 1'b1;
            state     <= ST_READ;
          end
        end
        ST_RESP: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid) else $error("ready while result pending");
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found) |-> (rsp.producer_task[30:0] >= live_watermark))
    else $error("dead entry reported");
  a_notfound: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.producer_task == NO_TASK))
    else $error("bad miss value");
  a_hash_only_busy: assert property (@(posedge clk) disable iff (rst)
    hctl.done |-> (state == ST_HASH)) else $error("hash done out of sequence");
`endif
endmodule

// ----- rtl/chpm_ram.sv -----
// Generic single-port RAM with registered read.
module chpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/chpm_hash.sv -----
// Multicycle partial fmix64: 32x32 partial products accumulated over cycles.
module chpm_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  import chpm_pkg::*;

  logic [63:0] x;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] a_part;
  logic [31:0] b_part;
  logic [63:0] prod;
  logic [63:0] prod_sh;

  // low 64 bits of x*M: lo*lo, (lo*hi)<<32, (hi*lo)<<32
  always_comb begin
    case (step)
      2'd0:    begin a_part = x[31:0];  b_part = MIX_MULT[31:0];  end
      2'd1:    begin a_part = x[31:0];  b_part = MIX_MULT[63:32]; end
      2'd2:    begin a_part = x[63:32]; b_part = MIX_MULT[31:0];  end
      default: begin a_part = x[63:32]; b_part = MIX_MULT[31:0];  end
    endcase
    prod    = 64'(a_part) * 64'(b_part);
    prod_sh = (step == 2'd0) ? prod : {prod[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= key ^ (key >> MIX_SHIFT);
        acc  <= '0;
      end else if (busy) begin
        acc  <= acc + prod_sh;
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign hash = acc ^ (acc >> MIX_SHIFT);
endmodule

// ----- dv/tb_chained_hash_producer_map.sv -----
// Testbench for the chained hash producer map: random and directed traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_chained_hash_producer_map;
  import chpm_pkg::*;

  localparam int NBKT = 256;
  localparam int POOL = 1024;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  chained_hash_producer_map #(.BUCKET_COUNT(NBKT), .SLOT_COUNT(POOL)) uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state
  logic        head_ok [NBKT];
  logic [9:0]  head_at [NBKT];
  logic [63:0] slot_key [POOL];
  logic [30:0] slot_task [POOL];
  logic        link_ok [POOL];
  logic [9:0]  link_at [POOL];
  logic [9:0]  next_slot;
  logic [30:0] watermark;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [63:0] used_handles[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [7:0] bucket_of(input logic [63:0] key);
    logic [63:0] h;
    h = key ^ (key >> MIX_SHIFT);
    h = h * MIX_MULT;
    h = h ^ (h >> MIX_SHIFT);
    return h[7:0];
  endfunction

  function automatic rsp_t predict_producer(input req_t r);
    rsp_t res;
    logic [7:0] b;
    logic ok;
    logic [9:0] cur;
    res.found = 1'b0;
    res.producer_task = NO_TASK;
    b = bucket_of(r.handle);
    case (r.mode)
      MODE_INSERT: begin
        slot_key[next_slot] = r.handle;
        slot_task[next_slot] = r.task_id;
        link_ok[next_slot] = head_ok[b];
        link_at[next_slot] = head_at[b];
        head_ok[b] = 1'b1;
        head_at[b] = next_slot;
        next_slot = next_slot + 1'b1;
      end
      MODE_LOOKUP: begin
        ok = head_ok[b];
        cur = head_at[b];
        for (int n = 0; n < POOL && ok; n++) begin
          if (slot_key[cur] == r.handle && slot_task[cur] >= watermark) begin
            res.found = 1'b1;
            res.producer_task = {1'b0, slot_task[cur]};
            break;
          end
          ok = link_ok[cur];
          cur = link_at[cur];
        end
      end
      MODE_WMARK: watermark = r.task_id;
      default: begin
        for (int i = 0; i < NBKT; i++) head_ok[i] = 1'b0;
        next_slot = '0;
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] m, input logic [63:0] h,
                                    input logic [30:0] t);
    req_t r;
    r.mode = m;
    r.handle = h;
    r.task_id = t;
    return r;
  endfunction

  function automatic logic [63:0] rand_handle();
    if (used_handles.size() > 0 && $urandom_range(0, 3) != 0)
      return used_handles[$urandom_range(0, used_handles.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(predict_producer(req));
        void'(pending_reqs.pop_front());
      end
      if (req_valid && !req_ready) begin
        // hold payload until accepted
      end else if (hold_sender || pending_reqs.size() == 0 ||
                   (req_valid && req_ready && pending_reqs.size() == 0)) begin
        req_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else begin
        req_valid <= 1'b1;
        req <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern and checker
  logic [7:0] stall_pat = 8'b1011_0110;
  always @(posedge clk) begin
    if (!rst) begin
      stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ stall_pat[4] ^ stall_pat[3]};
      rsp_ready <= ($urandom_range(0, 7) == 0) ? 1'b1 : !stall_pat[0] || stall_pat[1];
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no expectation: found=%0d producer_task=%0d",
                 rsp.found, rsp.producer_task);
          errors++;
        end else begin
          if (rsp.found !== expected_rsps[0].found) begin
            $error("found: expected %0d actual %0d", expected_rsps[0].found, rsp.found);
            errors++;
          end
          if (rsp.producer_task !== expected_rsps[0].producer_task) begin
            $error("producer_task: expected %0d actual %0d",
                   expected_rsps[0].producer_task, rsp.producer_task);
            errors++;
          end
          void'(expected_rsps.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] h;
    int m;
    for (int i = 0; i < NBKT; i++) head_ok[i] = 1'b0;
    next_slot = '0;
    watermark = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed
    pending_reqs.push_back(make_req(MODE_LOOKUP, 64'h0, 31'h0));
    pending_reqs.push_back(make_req(MODE_INSERT, 64'h0, 31'h0));
    pending_reqs.push_back(make_req(MODE_INSERT, '1, 31'h7FFF_FFFF));
    pending_reqs.push_back(make_req(MODE_INSERT, 64'h5555_AAAA_5555_AAAA, 31'h2AAA_AAAA));
    pending_reqs.push_back(make_req(MODE_INSERT, 64'h5555_AAAA_5555_AAAA, 31'h5555_5555));
    pending_reqs.push_back(make_req(MODE_LOOKUP, 64'h0, 31'h0));
    pending_reqs.push_back(make_req(MODE_LOOKUP, '1, '1));
    pending_reqs.push_back(make_req(MODE_LOOKUP, 64'h5555_AAAA_5555_AAAA, 31'h0));
    pending_reqs.push_back(make_req(MODE_WMARK, 64'h1234, 31'h4000_0000));
    pending_reqs.push_back(make_req(MODE_LOOKUP, 64'h5555_AAAA_5555_AAAA, 31'h0));
    pending_reqs.push_back(make_req(MODE_LOOKUP, 64'h0, 31'h0));
    pending_reqs.push_back(make_req(MODE_WMARK, 64'h0, 31'h7FFF_FFFF));
    pending_reqs.push_back(make_req(MODE_LOOKUP, '1, 31'h0));
    pending_reqs.push_back(make_req(MODE_WMARK, '1, 31'h0));
    pending_reqs.push_back(make_req(MODE_CLEAR, '1, '1));
    pending_reqs.push_back(make_req(MODE_LOOKUP, '1, 31'h0));
    pending_reqs.push_back(make_req(MODE_INSERT, 64'hDEAD_BEEF_0000_0001, 31'h1));
    pending_reqs.push_back(make_req(MODE_LOOKUP, 64'hDEAD_BEEF_0000_0001, 31'h0));
    used_handles.push_back(64'h0);
    used_handles.push_back('1);
    used_handles.push_back(64'h5555_AAAA_5555_AAAA);

    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    // once the block has drained, hold the sender off for a pause
    hold_sender = 1'b1;
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;

    // random: mostly inserts and lookups of known handles
    for (int n = 0; n < 930; n++) begin
      m = $urandom_range(0, 99);
      h = rand_handle();
      if (m < 45) begin
        pending_reqs.push_back(make_req(MODE_INSERT, h, 31'($urandom)));
        if (used_handles.size() < 64) used_handles.push_back(h);
        else used_handles[$urandom_range(0, 63)] = h;
      end else if (m < 90) begin
        pending_reqs.push_back(make_req(MODE_LOOKUP, h, 31'($urandom)));
      end else if (m < 98) begin
        pending_reqs.push_back(make_req(MODE_WMARK, {$urandom, $urandom},
          ($urandom_range(0, 1) == 0) ? 31'($urandom_range(0, 255)) : 31'($urandom)));
      end else if (n > 700) begin
        pending_reqs.push_back(make_req(MODE_CLEAR, {$urandom, $urandom}, 31'($urandom)));
      end else begin
        pending_reqs.push_back(make_req(MODE_LOOKUP, {$urandom, $urandom}, 31'($urandom)));
      end
    end

    wait (pending_reqs.size() == 0 && !req_valid);
    stim_done = 1'b1;
    for (int c = 0; c < IDLE_LIMIT && expected_rsps.size() != 0; c++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_rsps.size() != 0)
        $error("%0d expected results never arrived", expected_rsps.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
